// File: rtl/qcam_pkg.sv
// ----------------------------------------------------------------------------
// qcam_pkg
// shared types, widths and constants of the cascaded attitude mixer
// ----------------------------------------------------------------------------
package qcam_pkg;

	localparam int unsigned ANG_W   = 16;
	localparam int unsigned GAIN_W  = 8;
	localparam int unsigned BASE_W  = 10;
	localparam int unsigned OUT_W   = 10;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDAT_W  = 16;

	localparam int unsigned ERR_W   = ANG_W + 1;
	localparam int unsigned RT_W    = ERR_W + GAIN_W + 1;
	localparam int unsigned PROD_W  = RT_W + GAIN_W + 1;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned DRV_W   = PROD_W - FRAC_W;
	localparam int unsigned MIX_W   = 22;

	localparam int unsigned MOTOR_MAX_DEF = 999;

	localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 8'd32;
	localparam logic [GAIN_W-1:0] RATE_GAIN_RST  = 8'd80;
	localparam logic [BASE_W-1:0] BASE_RST       = 10'd200;

	typedef enum logic [CIDX_W-1:0] {
		REG_PITCH_TARGET = 3'd0,
		REG_ROLL_TARGET  = 3'd1,
		REG_PITCH_AGAIN  = 3'd2,
		REG_PITCH_RGAIN  = 3'd3,
		REG_ROLL_AGAIN   = 3'd4,
		REG_ROLL_RGAIN   = 3'd5,
		REG_BASE_THRUST  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] target;
		logic [GAIN_W-1:0]       angle_gain;
		logic [GAIN_W-1:0]       rate_gain;
	} axis_cfg_t;

endpackage

// File: rtl/quad_cascaded_attitude_mixer.sv
// ----------------------------------------------------------------------------
// quad_cascaded_attitude_mixer
// cascaded angle/rate p control on pitch and roll, x-frame motor mix
// ----------------------------------------------------------------------------
// throughput: one word per cycle, busy stays low, no result is ever held
// the six-stage pipeline has five per-axis stages and one mix/clamp stage
// reset: arst_n clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
module quad_cascaded_attitude_mixer
	import qcam_pkg::*;
#(
	parameter int unsigned MotorMax = MOTOR_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [ANG_W-1:0] pitch_angle,
	input  logic signed [ANG_W-1:0] pitch_rate,
	input  logic signed [ANG_W-1:0] roll_angle,
	input  logic signed [ANG_W-1:0] roll_rate,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CIDX_W-1:0]       cfg_index,
	input  logic [CDAT_W-1:0]       cfg_data,
	output logic                    done,
	output logic [OUT_W-1:0]        front_left,
	output logic [OUT_W-1:0]        front_right,
	output logic [OUT_W-1:0]        back_left,
	output logic [OUT_W-1:0]        back_right
);

	localparam logic signed [MIX_W-1:0] MAX_S   = MIX_W'(MotorMax);
	localparam logic [OUT_W-1:0]        MAX_OUT = OUT_W'(MotorMax);

	axis_cfg_t         pitch_cfg_q;
	axis_cfg_t         roll_cfg_q;
	logic [BASE_W-1:0] base_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, done_s6;

	logic signed [DRV_W-1:0] pitch_drv;
	logic signed [DRV_W-1:0] roll_drv;

	logic signed [MIX_W-1:0] base_x, pitch_x, roll_x;
	logic [OUT_W-1:0] fl_s6, fr_s6, bl_s6, br_s6;

	function automatic logic [OUT_W-1:0] clamp(input logic signed [MIX_W-1:0] v);
		logic [OUT_W-1:0] r;
		priority if (v > MAX_S) begin
			r = MAX_OUT;
		end else if (v <= 0) begin
			r = '0;
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_cfg_q <= '{target: '0, angle_gain: ANGLE_GAIN_RST, rate_gain: RATE_GAIN_RST};
			roll_cfg_q  <= '{target: '0, angle_gain: ANGLE_GAIN_RST, rate_gain: RATE_GAIN_RST};
			base_q      <= BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PITCH_TARGET: pitch_cfg_q.target     <= cfg_data;
				REG_ROLL_TARGET:  roll_cfg_q.target      <= cfg_data;
				REG_PITCH_AGAIN:  pitch_cfg_q.angle_gain <= cfg_data[GAIN_W-1:0];
				REG_PITCH_RGAIN:  pitch_cfg_q.rate_gain  <= cfg_data[GAIN_W-1:0];
				REG_ROLL_AGAIN:   roll_cfg_q.angle_gain  <= cfg_data[GAIN_W-1:0];
				REG_ROLL_RGAIN:   roll_cfg_q.rate_gain   <= cfg_data[GAIN_W-1:0];
				REG_BASE_THRUST:  base_q                 <= cfg_data[BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	qcam_axis u_pitch (
		.clk   (clk),
		.cfg   (pitch_cfg_q),
		.angle (pitch_angle),
		.rate  (pitch_rate),
		.drive (pitch_drv)
	);

	qcam_axis u_roll (
		.clk   (clk),
		.cfg   (roll_cfg_q),
		.angle (roll_angle),
		.rate  (roll_rate),
		.drive (roll_drv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			done_s6 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			done_s6 <= vld_s5;
		end
	end

	assign base_x  = $signed({{(MIX_W-BASE_W){1'b0}}, base_q});
	assign pitch_x = MIX_W'(pitch_drv);
	assign roll_x  = MIX_W'(roll_drv);

	always_ff @(posedge clk) begin
		fl_s6 <= clamp(base_x - pitch_x + roll_x);
		fr_s6 <= clamp(base_x - pitch_x - roll_x);
		bl_s6 <= clamp(base_x + pitch_x + roll_x);
		br_s6 <= clamp(base_x + pitch_x - roll_x);
	end

	assign done        = done_s6;
	assign front_left  = fl_s6;
	assign front_right = fr_s6;
	assign back_left   = bl_s6;
	assign back_right  = br_s6;

endmodule

// File: rtl/qcam_axis.sv
// ----------------------------------------------------------------------------
// qcam_axis
// five-stage cascaded proportional pipeline for one axis
// ----------------------------------------------------------------------------
module qcam_axis
	import qcam_pkg::*;
(
	input  logic                    clk,
	input  axis_cfg_t               cfg,
	input  logic signed [ANG_W-1:0] angle,
	input  logic signed [ANG_W-1:0] rate,
	output logic signed [DRV_W-1:0] drive
);

	logic signed [ERR_W-1:0]  err_s1;
	logic signed [ANG_W-1:0]  rate_s1;
	logic signed [RT_W-1:0]   rt_s2;
	logic signed [ANG_W-1:0]  rate_s2;
	logic signed [RT_W-1:0]   re_s3;
	logic signed [PROD_W-1:0] prod_s4;
	logic signed [DRV_W-1:0]  drive_s5;

	logic signed [RT_W-1:0]   rate_x16;
	logic                     trunc_fix;

	assign rate_x16  = {{(RT_W-ANG_W-4){rate_s2[ANG_W-1]}}, rate_s2, 4'b0000};
	assign trunc_fix = prod_s4[PROD_W-1] && (|prod_s4[FRAC_W-1:0]);

	always_ff @(posedge clk) begin
		err_s1   <= {cfg.target[ANG_W-1], cfg.target} - {angle[ANG_W-1], angle};
		rate_s1  <= rate;
		rt_s2    <= RT_W'(err_s1) * RT_W'($signed({1'b0, cfg.angle_gain}));
		rate_s2  <= rate_s1;
		re_s3    <= rt_s2 - rate_x16;
		prod_s4  <= PROD_W'(re_s3) * PROD_W'($signed({1'b0, cfg.rate_gain}));
		// toward-zero correction for negative values with a fraction
		drive_s5 <= prod_s4[PROD_W-1:FRAC_W] + $signed({{(DRV_W-1){1'b0}}, trunc_fix});
	end

	assign drive = drive_s5;

endmodule

// File: rtl/qcam_checker.sv
// ----------------------------------------------------------------------------
// qcam_port_checks
// port-level checks of the mixer: latency, pairing and output range
// ----------------------------------------------------------------------------
module qcam_port_checks
	import qcam_pkg::*;
#(
	parameter int unsigned MotorMax = MOTOR_MAX_DEF
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [OUT_W-1:0] front_left,
	input logic [OUT_W-1:0] front_right,
	input logic [OUT_W-1:0] back_left,
	input logic [OUT_W-1:0] back_right
);

	localparam logic [OUT_W-1:0] MAX_OUT = OUT_W'(MotorMax);

	a_word_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("accepted word gave no done strobe");

	a_done_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("done strobe without an accepted word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (front_left <= MAX_OUT && front_right <= MAX_OUT &&
			back_left <= MAX_OUT && back_right <= MAX_OUT))
		else $error("motor command above limit");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while results stream");

endmodule

bind quad_cascaded_attitude_mixer qcam_port_checks #(
	.MotorMax (MotorMax)
) u_qcam_port_checks (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.front_left  (front_left),
	.front_right (front_right),
	.back_left   (back_left),
	.back_right  (back_right)
);

// File: verif/qcam_checker.sv
// ----------------------------------------------------------------------------
// qcam_checker
// watches the sample, register and motor channels of the attitude mixer,
// predicts every motor set from the accepted sample and the register copy,
// and compares each done word field by field in arrival order
// ----------------------------------------------------------------------------
module qcam_checker
	import qcam_pkg::*;
#(
	parameter int unsigned MotorMax = MOTOR_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic signed [ANG_W-1:0] pitch_angle,
	input  logic signed [ANG_W-1:0] pitch_rate,
	input  logic signed [ANG_W-1:0] roll_angle,
	input  logic signed [ANG_W-1:0] roll_rate,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CIDX_W-1:0]       cfg_index,
	input  logic [CDAT_W-1:0]       cfg_data,
	input  logic                    done,
	input  logic [OUT_W-1:0]        front_left,
	input  logic [OUT_W-1:0]        front_right,
	input  logic [OUT_W-1:0]        back_left,
	input  logic [OUT_W-1:0]        back_right,
	output int                      mismatches,
	output int                      outstanding,
	output int                      checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OUT_W-1:0] fl;
		logic [OUT_W-1:0] fr;
		logic [OUT_W-1:0] bl;
		logic [OUT_W-1:0] br;
	} motor_set_t;

	motor_set_t expected_cmds[$];

	longint pitch_sp, roll_sp, pitch_again, pitch_inner_gain, roll_again, roll_inner_gain;
	longint thrust;
	int     errs = 0;
	int     seen = 0;

	function automatic longint axis_effort(longint sp, longint angle, longint rate,
			longint outer_gain, longint inner_gain);
		longint rate_sp;
		longint rate_err;
		rate_sp  = (sp - angle) * outer_gain;
		rate_err = rate_sp - rate * 16;
		return (rate_err * inner_gain) / 65536;
	endfunction

	function automatic logic [OUT_W-1:0] motor_cmd(longint v);
		longint lim;
		lim = MotorMax;
		if (v > lim) begin
			v = lim;
		end else if (v <= 0) begin
			v = 0;
		end
		return v[OUT_W-1:0];
	endfunction

	function automatic motor_set_t mix_sample();
		longint     p;
		longint     r;
		motor_set_t m;
		p = axis_effort(pitch_sp, longint'(pitch_angle), longint'(pitch_rate),
			pitch_again, pitch_inner_gain);
		r = axis_effort(roll_sp, longint'(roll_angle), longint'(roll_rate),
			roll_again, roll_inner_gain);
		m.fl = motor_cmd(thrust - p + r);
		m.fr = motor_cmd(thrust - p - r);
		m.bl = motor_cmd(thrust + p + r);
		m.br = motor_cmd(thrust + p - r);
		return m;
	endfunction

	task automatic report(input string msg);
		errs++;
		$display("[%0t] %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		if (got !== want) begin
			report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		motor_set_t want;
		if (!arst_n) begin
			pitch_sp         = 0;
			roll_sp          = 0;
			pitch_again      = longint'(ANGLE_GAIN_RST);
			pitch_inner_gain = longint'(RATE_GAIN_RST);
			roll_again       = longint'(ANGLE_GAIN_RST);
			roll_inner_gain  = longint'(RATE_GAIN_RST);
			thrust           = longint'(BASE_RST);
			expected_cmds.delete();
		end else begin
			if (done) begin
				if (expected_cmds.size() == 0) begin
					report($sformatf("motor word with nothing expected: %0d %0d %0d %0d",
						front_left, front_right, back_left, back_right));
				end else begin
					want = expected_cmds.pop_front();
					check_field("front_left", front_left, want.fl);
					check_field("front_right", front_right, want.fr);
					check_field("back_left", back_left, want.bl);
					check_field("back_right", back_right, want.br);
					seen++;
				end
			end
			if (start && !busy) begin
				expected_cmds.push_back(mix_sample());
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_PITCH_TARGET: pitch_sp         = longint'(signed'(cfg_data));
					REG_ROLL_TARGET:  roll_sp          = longint'(signed'(cfg_data));
					REG_PITCH_AGAIN:  pitch_again      = longint'(cfg_data[GAIN_W-1:0]);
					REG_PITCH_RGAIN:  pitch_inner_gain = longint'(cfg_data[GAIN_W-1:0]);
					REG_ROLL_AGAIN:   roll_again       = longint'(cfg_data[GAIN_W-1:0]);
					REG_ROLL_RGAIN:   roll_inner_gain  = longint'(cfg_data[GAIN_W-1:0]);
					REG_BASE_THRUST:  thrust           = longint'(cfg_data[BASE_W-1:0]);
					default: ;
				endcase
			end
		end
		mismatches  <= errs;
		outstanding <= expected_cmds.size();
		checked     <= seen;
	end

endmodule

// File: verif/quad_cascaded_attitude_mixer_tb.sv
// ----------------------------------------------------------------------------
// quad_cascaded_attitude_mixer_tb
// drives imu samples and register settings into the attitude mixer: a
// directed set of extreme angles, rates, gains and thrust levels, then
// random register phases with bursty or steady sample traffic; a checker module beside
// the block predicts and compares every motor word
// ----------------------------------------------------------------------------
module quad_cascaded_attitude_mixer_tb;
	import qcam_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                STALL_LIMIT  = 2000;
	localparam int                LATENCY      = 6;
	localparam int                PHASE_ITEMS  = 160;
	localparam int                PHASES       = 11;
	localparam logic [CIDX_W-1:0] REG_UNMAPPED = 3'd7;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [ANG_W-1:0] pitch_angle;
	logic signed [ANG_W-1:0] pitch_rate;
	logic signed [ANG_W-1:0] roll_angle;
	logic signed [ANG_W-1:0] roll_rate;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CIDX_W-1:0]       cfg_index;
	logic [CDAT_W-1:0]       cfg_data;
	logic                    done;
	logic [OUT_W-1:0]        front_left;
	logic [OUT_W-1:0]        front_right;
	logic [OUT_W-1:0]        back_left;
	logic [OUT_W-1:0]        back_right;
	int                      mismatches;
	int                      outstanding;
	int                      checked;

	logic [ANG_W-1:0] pitch_sp_now;
	logic [ANG_W-1:0] roll_sp_now;
	int               samples_sent = 0;
	int               settings = 0;
	int               quiet_cycles = 0;
	int               burst_left = 1;
	bit               steady = 1'b1;

	quad_cascaded_attitude_mixer dut (.*);
	qcam_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("no traffic for %0d cycles, %0d words still expected",
				STALL_LIMIT, outstanding);
			$display("quad_cascaded_attitude_mixer_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_sample(input logic [ANG_W-1:0] pa, input logic [ANG_W-1:0] pr,
			input logic [ANG_W-1:0] ra, input logic [ANG_W-1:0] rr);
		start       <= 1'b1;
		pitch_angle <= pa;
		pitch_rate  <= pr;
		roll_angle  <= ra;
		roll_rate   <= rr;
		do @(posedge clk); while (busy);
		samples_sent++;
		if (!steady) begin
			burst_left--;
			if (burst_left <= 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	task automatic settle_pipeline();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_all(input logic [CDAT_W-1:0] pt, input logic [CDAT_W-1:0] rt,
			input logic [CDAT_W-1:0] pag, input logic [CDAT_W-1:0] prg,
			input logic [CDAT_W-1:0] rag, input logic [CDAT_W-1:0] rrg,
			input logic [CDAT_W-1:0] base, input bit stray);
		settle_pipeline();
		write_reg(REG_PITCH_TARGET, pt);
		write_reg(REG_ROLL_TARGET, rt);
		write_reg(REG_PITCH_AGAIN, pag);
		write_reg(REG_PITCH_RGAIN, prg);
		write_reg(REG_ROLL_AGAIN, rag);
		write_reg(REG_ROLL_RGAIN, rrg);
		write_reg(REG_BASE_THRUST, base);
		if (stray) begin
			write_reg(REG_UNMAPPED, CDAT_W'($urandom));
		end
		cfg_valid    <= 1'b0;
		pitch_sp_now = pt;
		roll_sp_now  = rt;
		settings++;
	endtask

	// mostly small errors around the set points, the rest fully random samples
	task automatic random_sample();
		if ($urandom_range(0, 9) < 4) begin
			send_sample(ANG_W'($urandom), ANG_W'($urandom), ANG_W'($urandom),
				ANG_W'($urandom));
		end else begin
			send_sample(pitch_sp_now + ANG_W'($urandom_range(0, 4095) - 2048),
				ANG_W'($urandom_range(0, 4095) - 2048),
				roll_sp_now + ANG_W'($urandom_range(0, 4095) - 2048),
				ANG_W'($urandom_range(0, 4095) - 2048));
		end
	endtask

	function automatic logic [CDAT_W-1:0] pick_gain(int kind);
		case (kind)
			0: return CDAT_W'($urandom);
			3: return $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
			default: return {8'($urandom), 8'($urandom_range(0, 96))};
		endcase
	endfunction

	initial begin
		int kind;
		logic [CDAT_W-1:0] pt;
		logic [CDAT_W-1:0] rt;
		logic [CDAT_W-1:0] base;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		pitch_angle  <= '0;
		pitch_rate   <= '0;
		roll_angle   <= '0;
		roll_rate    <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		pitch_sp_now = '0;
		roll_sp_now  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight out of reset
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000);
		send_sample(16'h0000, 16'h7FFF, 16'h0000, 16'h8000);
		send_sample(16'h0100, 16'hFF80, 16'hFFC0, 16'h0020);
		send_sample(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF);
		send_sample(16'hFE00, 16'h0300, 16'h0200, 16'hFD00);

		// thrust above range, max gains, extreme set points, stray index
		program_all(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 1'b1);
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
		send_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_sample(16'h7FFF, 16'h0000, 16'h8000, 16'h0000);

		// zero gains and zero thrust
		program_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 1'b0);
		send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_sample(16'h1234, 16'hEDCB, 16'h5A5A, 16'hA5A5);

		// full thrust at the motor limit
		program_all(16'h0000, 16'h0000, 16'h0020, 16'h0050, 16'h0020, 16'h0050,
			16'd999, 1'b0);
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0100, 16'h0000, 16'hFF00, 16'h0000);
		send_sample(16'hFF00, 16'h0000, 16'h0100, 16'h0000);

		for (int ph = 0; ph < PHASES; ph++) begin
			kind = $urandom_range(0, 3);
			case (kind)
				0: begin
					pt   = CDAT_W'($urandom);
					rt   = CDAT_W'($urandom);
					base = CDAT_W'($urandom);
				end
				3: begin
					pt   = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
					rt   = $urandom_range(0, 1) ? 16'h0000 : 16'h8000;
					base = $urandom_range(0, 1) ? 16'd0 : 16'd1023;
				end
				default: begin
					pt   = CDAT_W'($urandom_range(0, 4095) - 2048);
					rt   = CDAT_W'($urandom_range(0, 4095) - 2048);
					base = {6'($urandom), 10'($urandom_range(150, 850))};
				end
			endcase
			program_all(pt, rt, pick_gain(kind), pick_gain(kind), pick_gain(kind),
				pick_gain(kind), base, $urandom_range(0, 2) == 0);
			steady     = $urandom_range(0, 3) == 0;
			burst_left = $urandom_range(1, 12);
			repeat (PHASE_ITEMS) random_sample();
		end

		settle_pipeline();
		repeat (LATENCY + 4) @(posedge clk);
		$display("%0d imu samples over %0d register settings, %0d motor words checked",
			samples_sent, settings + 1, checked);
		if (mismatches == 0 && outstanding == 0) begin
			$display("quad_cascaded_attitude_mixer_tb passed");
		end else begin
			$display("quad_cascaded_attitude_mixer_tb failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/qcam_pkg.sv
rtl/qcam_axis.sv
rtl/quad_cascaded_attitude_mixer.sv
rtl/qcam_checker.sv
verif/qcam_checker.sv
verif/quad_cascaded_attitude_mixer_tb.sv
